/* design/gpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpr_pkg: shared types and constants of the GPIO port register block
// Register offsets, action and status codes, reset values, control struct.
// ----------------------------------------------------------------------------
package gpr_pkg;

	localparam int unsigned PIN_COUNT = 16;
	localparam logic [31:0] RESET_MODE_WORD = 32'ha800_0000;
	localparam logic [15:0] PIN_MASK = 16'((17'(1) << PIN_COUNT) - 17'(1));

	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 80;

	typedef enum logic [2:0] {
		ACT_READ      = 3'd0,
		ACT_WR_WORD   = 3'd1,
		ACT_WR_HALF   = 3'd2,
		ACT_WR_OTHER  = 3'd3,
		ACT_PIN_EVENT = 3'd4
	} gpr_action_t;

	localparam logic [9:0] OFS_MODE    = 10'h000;
	localparam logic [9:0] OFS_TYPE    = 10'h004;
	localparam logic [9:0] OFS_SPEED   = 10'h008;
	localparam logic [9:0] OFS_PULL    = 10'h00c;
	localparam logic [9:0] OFS_IN      = 10'h010;
	localparam logic [9:0] OFS_OUT     = 10'h014;
	localparam logic [9:0] OFS_SETCLR  = 10'h018;
	localparam logic [9:0] OFS_SETCLR2 = 10'h01a;
	localparam logic [9:0] OFS_LOCK    = 10'h01c;
	localparam logic [9:0] OFS_AFLO    = 10'h020;
	localparam logic [9:0] OFS_AFHI    = 10'h024;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNMODELED = 2'd1;
	localparam logic [1:0] ST_BAD       = 2'd2;

	localparam logic [1:0] MODE_OUTPUT = 2'd1;

	typedef struct packed {
		logic load;   // capture the incoming request
		logic exec;   // apply request, load result register
	} gpr_cmd_t;

endpackage : gpr_pkg
`default_nettype wire

/* design/gpr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpr_ctrl: request sequencer
// Captures one request, executes it once the result register is free, and
// tracks result valid.
// ----------------------------------------------------------------------------
module gpr_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output gpr_pkg::gpr_cmd_t   cmd
);
	import gpr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} gpr_state_t;

	gpr_state_t state_q;
	logic       out_valid_q;
	logic       exec_go;

	assign s_tready = (state_q == S_IDLE);
	assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || m_tready);
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = exec_go;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (exec_go) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule : gpr_ctrl
`default_nettype wire

/* design/gpr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpr_datapath: port registers and access decode
// Holds mode, output data, alternate-function words and input levels;
// decodes the captured request and builds the result.
// ----------------------------------------------------------------------------
module gpr_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire gpr_pkg::gpr_cmd_t               cmd,
	input  wire logic [2:0]                      in_action,
	input  wire logic [gpr_pkg::IN_DATA_W-1:0]   in_data,
	output logic [gpr_pkg::OUT_DATA_W-1:0]       res_data,
	output logic [1:0]                           res_status
);
	import gpr_pkg::*;

	logic [2:0]  act_q;
	logic [9:0]  ofs_q;
	logic [31:0] wdata_q;
	logic [3:0]  pin_q;
	logic        lvl_q;

	logic [31:0] mode_q;
	logic [15:0] out_q;
	logic [31:0] aflo_q;
	logic [31:0] afhi_q;
	logic [15:0] inl_q;

	logic [31:0] rd_q;
	logic [15:0] lvls_q;
	logic [15:0] chg_q;
	logic [15:0] inow_q;
	logic [1:0]  st_q;

	logic [31:0] mode_n, aflo_n, afhi_n, rd_n;
	logic [15:0] out_n, inl_n, pins_old, pins_new;
	logic [1:0]  st_n;

	always_comb begin
		for (int p = 0; p < 16; p++) begin
			pins_old[p] = (mode_q[2*p +: 2] == MODE_OUTPUT);
			pins_new[p] = (mode_n[2*p +: 2] == MODE_OUTPUT);
		end
		pins_old = pins_old & PIN_MASK;
		pins_new = pins_new & PIN_MASK;
	end

	always_comb begin
		mode_n = mode_q;
		out_n  = out_q;
		aflo_n = aflo_q;
		afhi_n = afhi_q;
		inl_n  = inl_q;
		rd_n   = '0;
		st_n   = ST_OK;
		case (act_q)
			ACT_READ: begin
				case (ofs_q)
					OFS_MODE: rd_n = mode_q;
					OFS_IN:   rd_n = {16'h0, inl_q};
					OFS_OUT:  rd_n = {16'h0, out_q};
					OFS_AFLO: rd_n = aflo_q;
					OFS_AFHI: rd_n = afhi_q;
					default: begin
						if (ofs_q inside {OFS_TYPE, OFS_SPEED, OFS_PULL, OFS_SETCLR, OFS_LOCK})
							st_n = ST_UNMODELED;
						else
							st_n = ST_BAD;
					end
				endcase
			end
			ACT_WR_WORD: begin
				case (ofs_q)
					OFS_MODE:   mode_n = wdata_q;
					OFS_OUT:    out_n  = wdata_q[15:0];
					OFS_SETCLR: out_n  = (out_q & ~wdata_q[31:16]) | wdata_q[15:0];
					OFS_AFLO:   aflo_n = wdata_q;
					OFS_AFHI:   afhi_n = wdata_q;
					default: begin
						if (ofs_q inside {OFS_TYPE, OFS_SPEED, OFS_PULL, OFS_IN, OFS_LOCK})
							st_n = ST_UNMODELED;
						else
							st_n = ST_BAD;
					end
				endcase
			end
			ACT_WR_HALF: begin
				if (ofs_q == OFS_SETCLR) out_n = out_q | wdata_q[15:0];
				else if (ofs_q == OFS_SETCLR2) out_n = out_q & ~wdata_q[15:0];
				else st_n = ST_BAD;
			end
			ACT_PIN_EVENT: begin
				if (PIN_MASK[pin_q]) inl_n[pin_q] = lvl_q;
				else st_n = ST_BAD;
			end
			default: st_n = ST_BAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= in_action;
			ofs_q   <= in_data[9:0];
			wdata_q <= in_data[41:10];
			pin_q   <= in_data[45:42];
			lvl_q   <= in_data[46];
		end
		if (cmd.exec) begin
			rd_q   <= rd_n;
			lvls_q <= out_n & pins_new;
			chg_q  <= (out_q ^ out_n) & pins_old;
			inow_q <= inl_n;
			st_q   <= st_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RESET_MODE_WORD;
			out_q  <= '0;
			aflo_q <= '0;
			afhi_q <= '0;
			inl_q  <= '0;
		end else if (cmd.exec) begin
			mode_q <= mode_n;
			out_q  <= out_n;
			aflo_q <= aflo_n;
			afhi_q <= afhi_n;
			inl_q  <= inl_n;
		end
	end

	assign res_data   = {inow_q, chg_q, lvls_q, rd_q};
	assign res_status = st_q;

endmodule : gpr_datapath
`default_nettype wire

/* design/gpio_port_registers.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpio_port_registers: 16-pin GPIO port register block
// Register reads/writes and external pin events on one request stream,
// one result per request.
// ----------------------------------------------------------------------------
// channel | dir | payload
// s_*     | in  | tuser: action; tdata: offset, write data, pin, level
// m_*     | out | tuser: status; tdata: read data, levels, changed, inputs
//
// Each request is captured, then executed into the result register.
// Execute waits while the result register is full and not taken.
// A new request is captured while a result waits downstream.
// arst_n restores the mode word and clears output, AF, input and control state.
// ----------------------------------------------------------------------------
module gpio_port_registers (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [9:0] reg_offset, [41:10] write_data, [45:42] pin_index, [46] pin_level
	input  wire logic [gpr_pkg::IN_DATA_W-1:0]   s_tdata,
	// [2:0] action
	input  wire logic [2:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [31:0] read_data, [47:32] output_levels, [63:48] drive_changed,
	// [79:64] input_levels_now
	output logic [gpr_pkg::OUT_DATA_W-1:0]       m_tdata,
	// [1:0] status
	output logic [1:0]                           m_tuser
);
	import gpr_pkg::*;

	gpr_cmd_t cmd;

	gpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	gpr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_action  (s_tuser),
		.in_data    (s_tdata),
		.res_data   (m_tdata),
		.res_status (m_tuser)
	);

endmodule : gpio_port_registers
`default_nettype wire
